// ----- src/sbrt_pkg.sv -----
// shared types, field widths and codes for the snapshot block remap table
`default_nettype none
package sbrt_pkg;

    // field widths of the request and result beats
    localparam int OP_W      = 2;
    localparam int SNAP_ID_W = 2;
    localparam int BLOCK_W   = 32;
    localparam int STATUS_W  = 4;
    localparam int SLOT_W    = 6;

    // operation codes
    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_FREEZE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_CREATED      = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NEW_COPY     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NEW_FETCH    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FROZEN       = 4'd3;
    localparam logic [STATUS_W-1:0] ST_HIT          = 4'd4;
    localparam logic [STATUS_W-1:0] ST_MISS_BACKEND = 4'd5;
    localparam logic [STATUS_W-1:0] ST_DELETED      = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_ID       = 4'd7;
    localparam logic [STATUS_W-1:0] ST_NO_SOURCE    = 4'd8;
    localparam logic [STATUS_W-1:0] ST_FULL         = 4'd9;
    localparam logic [STATUS_W-1:0] ST_NO_SNAPSHOT  = 4'd10;
    localparam logic [STATUS_W-1:0] ST_MISS_NONE    = 4'd11;

    // sequencer to compare unit control
    typedef struct packed {
        logic clear;  // start of a new scan
        logic step;   // one stored entry is being read this cycle
        logic live;   // live bit of the entry being read
    } t_scan_ctl;

    // compare unit summary back to the sequencer
    typedef struct packed {
        logic hit;    // a live entry holds the key
        logic free;   // a free entry was seen
    } t_scan_res;

endpackage
`default_nettype wire

// ----- src/sbrt_ram.sv -----
// generic single write, single read ram with registered read data
`default_nettype none
module sbrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- src/sbrt_scan.sv -----
// shared compare unit: one stored block number per cycle against the key
`default_nettype none
module sbrt_scan #(
    parameter int CW = 6
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  sbrt_pkg::t_scan_ctl              i_ctl,
    input  wire [CW-1:0]                     i_idx,
    input  wire [sbrt_pkg::BLOCK_W-1:0]      i_key,
    input  wire [sbrt_pkg::BLOCK_W-1:0]      i_rdata,
    output sbrt_pkg::t_scan_res              o_res,
    output logic [CW-1:0]                    o_hit_idx,
    output logic [CW-1:0]                    o_free_idx
);

    logic          r_pend;
    logic          r_plive;
    logic [CW-1:0] r_pidx;
    logic          r_hit;
    logic          r_free;
    logic [CW-1:0] r_hit_idx;
    logic [CW-1:0] r_free_idx;
    logic          w_match;
    logic          w_empty;

    // read data arrives in the cycle after the address, so the step is delayed
    assign w_match = r_pend && r_plive && (i_rdata == i_key) && !r_hit;
    assign w_empty = r_pend && !r_plive && !r_free;

    // pending step pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_ctl.step && !i_ctl.clear;
        end
        r_plive <= i_ctl.live;
        r_pidx  <= i_idx;
    end

    // first hit and first free entry, lowest index wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_ctl.clear) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (w_match) begin
                r_hit <= 1'b1;
            end
            if (w_empty) begin
                r_free <= 1'b1;
            end
        end
        if (w_match) begin
            r_hit_idx <= r_pidx;
        end
        if (w_empty) begin
            r_free_idx <= r_pidx;
        end
    end

    assign o_res.hit  = r_hit;
    assign o_res.free = r_free;
    assign o_hit_idx  = r_hit_idx;
    assign o_free_idx = r_free_idx;

endmodule
`default_nettype wire

// ----- src/snapshot_block_remap_table_top.sv -----
// top level: request sequencer, live bits and block number store
//
// Request channel: i_in_valid with o_in_stall; a beat carries op, snap_id,
// block and has_old_data. Result channel: o_out_valid with i_out_stall; a
// beat carries status, new_snap_id and slot. Exactly one result per request.
// Config: i_cfg_wr_en writes i_cfg_wr_data into the backend-present bit.
//
// One request is worked on at a time; o_in_stall is high from accept until
// the result is placed in the output register. Freeze and read scan all
// CHANGES entries of the snapshot through one comparator, one stored block
// number per cycle from the ram. Create walks the snapshot live bits one per
// cycle. The result beat becomes valid in the same cycle that the next
// request can be accepted.
//
// Reset clears all snapshot and entry live bits, the backend bit and the
// output valid; stored block numbers are only read behind a live bit, so the
// ram needs no clearing pass. A stalled result stays in the output register;
// the next request is still accepted and worked on, and it waits only at the
// end for the output register to empty.
`default_nettype none
module snapshot_block_remap_table_top #(
    parameter int SNAPSHOTS = 4,
    parameter int CHANGES   = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire                                 i_cfg_wr_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire [sbrt_pkg::OP_W-1:0]            i_op,
    input  wire [sbrt_pkg::SNAP_ID_W-1:0]       i_snap_id,
    input  wire [sbrt_pkg::BLOCK_W-1:0]         i_block,
    input  wire                                 i_has_old_data,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [sbrt_pkg::STATUS_W-1:0]       o_status,
    output logic [sbrt_pkg::SNAP_ID_W-1:0]      o_new_snap_id,
    output logic [sbrt_pkg::SLOT_W-1:0]         o_slot
);

    localparam int SW = (SNAPSHOTS > 1) ? $clog2(SNAPSHOTS) : 1;
    localparam int CW = (CHANGES > 1) ? $clog2(CHANGES) : 1;
    localparam int AW = SW + CW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_CSCAN,
        S_ESCAN,
        S_EWAIT,
        S_EDECIDE,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic                              r_backend;
    logic [sbrt_pkg::OP_W-1:0]         r_op, n_op;
    logic [sbrt_pkg::SNAP_ID_W-1:0]    r_snap_id, n_snap_id;
    logic [sbrt_pkg::BLOCK_W-1:0]      r_blk, n_blk;
    logic                              r_old, n_old;
    logic [SW-1:0]                     r_sidx, n_sidx;
    logic [CW-1:0]                     r_idx, n_idx;
    logic [sbrt_pkg::STATUS_W-1:0]     r_res_status, n_res_status;
    logic [sbrt_pkg::SNAP_ID_W-1:0]    r_res_newid, n_res_newid;
    logic [sbrt_pkg::SLOT_W-1:0]       r_res_slot, n_res_slot;
    logic                              r_out_valid, n_out_valid;
    logic [sbrt_pkg::STATUS_W-1:0]     r_out_status, n_out_status;
    logic [sbrt_pkg::SNAP_ID_W-1:0]    r_out_newid, n_out_newid;
    logic [sbrt_pkg::SLOT_W-1:0]       r_out_slot, n_out_slot;

    logic [SNAPSHOTS-1:0]              r_snap_live;
    logic [CHANGES-1:0]                r_entry_live [SNAPSHOTS];

    logic [SW-1:0]                     w_sid;
    logic                              w_sid_ok;
    logic [SW-1:0]                     w_row;
    logic                              w_snap_set;
    logic                              w_snap_clr;
    logic                              w_row_clr;
    logic                              w_ent_set;
    logic                              w_we;
    sbrt_pkg::t_scan_ctl               w_ctl;
    sbrt_pkg::t_scan_res               w_res;
    logic [CW-1:0]                     w_hit_idx;
    logic [CW-1:0]                     w_free_idx;
    logic [sbrt_pkg::BLOCK_W-1:0]      w_rdata;

    // snapshot index of the current request
    assign w_sid    = SW'(r_snap_id);
    assign w_sid_ok = ({30'd0, r_snap_id} < 32'(SNAPSHOTS)) && r_snap_live[w_sid];
    assign w_row    = (r_state == S_CSCAN) ? r_sidx : w_sid;

    // block number store
    sbrt_ram #(
        .WIDTH (sbrt_pkg::BLOCK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({w_sid, w_free_idx}),
        .i_wdata (r_blk),
        .i_raddr ({w_sid, r_idx}),
        .o_rdata (w_rdata)
    );

    // shared comparator
    sbrt_scan #(
        .CW (CW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_idx),
        .i_key      (r_blk),
        .i_rdata    (w_rdata),
        .o_res      (w_res),
        .o_hit_idx  (w_hit_idx),
        .o_free_idx (w_free_idx)
    );

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_snap_id    = r_snap_id;
        n_blk        = r_blk;
        n_old        = r_old;
        n_sidx       = r_sidx;
        n_idx        = r_idx;
        n_res_status = r_res_status;
        n_res_newid  = r_res_newid;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_newid  = r_out_newid;
        n_out_slot   = r_out_slot;
        w_snap_set   = 1'b0;
        w_snap_clr   = 1'b0;
        w_row_clr    = 1'b0;
        w_ent_set    = 1'b0;
        w_we         = 1'b0;
        w_ctl        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_op;
                    n_snap_id = i_snap_id;
                    n_blk     = i_block;
                    n_old     = i_has_old_data;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_newid = '0;
                n_res_slot  = '0;
                priority if (r_op == sbrt_pkg::OP_CREATE) begin
                    n_sidx  = '0;
                    n_state = S_CSCAN;
                end else if (!w_sid_ok) begin
                    n_res_status = sbrt_pkg::ST_BAD_ID;
                    n_state      = S_OUT;
                end else if (r_op == sbrt_pkg::OP_DELETE) begin
                    w_snap_clr   = 1'b1;
                    w_row_clr    = 1'b1;
                    n_res_status = sbrt_pkg::ST_DELETED;
                    n_state      = S_OUT;
                end else begin
                    w_ctl.clear = 1'b1;
                    n_idx       = '0;
                    n_state     = S_ESCAN;
                end
            end
            S_CSCAN: begin
                priority if (!r_snap_live[r_sidx]) begin
                    w_snap_set   = 1'b1;
                    w_row_clr    = 1'b1;
                    n_res_status = sbrt_pkg::ST_CREATED;
                    n_res_newid  = sbrt_pkg::SNAP_ID_W'(r_sidx);
                    n_state      = S_OUT;
                end else if (r_sidx == SW'(SNAPSHOTS - 1)) begin
                    n_res_status = sbrt_pkg::ST_NO_SNAPSHOT;
                    n_state      = S_OUT;
                end else begin
                    n_sidx = r_sidx + 1'b1;
                end
            end
            S_ESCAN: begin
                w_ctl.step = 1'b1;
                w_ctl.live = r_entry_live[w_sid][r_idx];
                if (r_idx == CW'(CHANGES - 1)) begin
                    n_state = S_EWAIT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EWAIT: begin
                n_state = S_EDECIDE;
            end
            S_EDECIDE: begin
                n_state = S_OUT;
                if (r_op == sbrt_pkg::OP_FREEZE) begin
                    priority if (w_res.hit) begin
                        n_res_status = sbrt_pkg::ST_FROZEN;
                        n_res_slot   = sbrt_pkg::SLOT_W'(w_hit_idx);
                    end else if (!w_res.free) begin
                        n_res_status = sbrt_pkg::ST_FULL;
                    end else if (r_old || r_backend) begin
                        w_we         = 1'b1;
                        w_ent_set    = 1'b1;
                        n_res_status = r_old ? sbrt_pkg::ST_NEW_COPY : sbrt_pkg::ST_NEW_FETCH;
                        n_res_slot   = sbrt_pkg::SLOT_W'(w_free_idx);
                    end else begin
                        n_res_status = sbrt_pkg::ST_NO_SOURCE;
                    end
                end else begin
                    if (w_res.hit) begin
                        n_res_status = sbrt_pkg::ST_HIT;
                        n_res_slot   = sbrt_pkg::SLOT_W'(w_hit_idx);
                    end else begin
                        n_res_status = r_backend ? sbrt_pkg::ST_MISS_BACKEND
                                                 : sbrt_pkg::ST_MISS_NONE;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_newid  = r_res_newid;
                    n_out_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, request and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_backend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_backend <= i_cfg_wr_data;
            end
        end
        r_op         <= n_op;
        r_snap_id    <= n_snap_id;
        r_blk        <= n_blk;
        r_old        <= n_old;
        r_sidx       <= n_sidx;
        r_idx        <= n_idx;
        r_res_status <= n_res_status;
        r_res_newid  <= n_res_newid;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_newid  <= n_out_newid;
        r_out_slot   <= n_out_slot;
    end

    // snapshot and entry live bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_live <= '0;
            for (int s = 0; s < SNAPSHOTS; s++) begin
                r_entry_live[s] <= '0;
            end
        end else begin
            if (w_snap_set) begin
                r_snap_live[w_row] <= 1'b1;
            end
            if (w_snap_clr) begin
                r_snap_live[w_row] <= 1'b0;
            end
            if (w_row_clr) begin
                r_entry_live[w_row] <= '0;
            end
            if (w_ent_set) begin
                r_entry_live[w_sid][w_free_idx] <= 1'b1;
            end
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_new_snap_id = r_out_newid;
    assign o_slot        = r_out_slot;

    // entries are only scanned in a live snapshot
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ESCAN) |-> r_snap_live[w_sid])
        else $error("entry scan in a snapshot that is not live");

    // a reported hit points at a live entry
    a_hit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDECIDE && w_res.hit) |-> r_entry_live[w_sid][w_hit_idx])
        else $error("hit on an entry that is not live");

    // a claimed change slot was free
    a_claim_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ent_set |-> !r_entry_live[w_sid][w_free_idx])
        else $error("claimed change slot already live");

endmodule
`default_nettype wire
